>>> design/fixed_point_dense_neuron_macros.svh
// assertion macros shared by the fixed point dense neuron rtl
// expects clk and rst_n in the scope of each use
`ifndef FIXED_POINT_DENSE_NEURON_MACROS_SVH
`define FIXED_POINT_DENSE_NEURON_MACROS_SVH

// property checked at every clock edge outside reset
`define FPDN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// condition in one cycle implies a check in the next cycle
`define FPDN_ASSERT_NEXT(label, cond, check, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (check)) \
    else $error(msg);

`endif

>>> design/fpdn_pkg.sv
// shared types and constants of the fixed point dense neuron
// no dependencies
package fpdn_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FRAC_BITS     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BIAS_ENABLE   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RELU_ENABLE   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_SCALE  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_OFFSET = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_BIAS_SCALE    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_BIAS_OFFSET   = 3'd6;

  typedef struct packed {
    logic [5:0]         frac_bits;
    logic               bias_enable;
    logic               relu_enable;
    logic signed [31:0] weight_scale;
    logic signed [31:0] weight_offset;
    logic signed [31:0] bias_scale;
    logic signed [31:0] bias_offset;
  } cfg_t;

  // one dequantized term as it waits between front and back
  typedef struct packed {
    logic signed [31:0] weight;
    logic signed [31:0] activation;
    logic               last_term;
    logic signed [31:0] bias;
  } term_t;

endpackage

>>> design/fixed_point_dense_neuron.sv
// top level of the fixed point dense neuron
// depends on fpdn_pkg, fpdn_fifo, fpdn_front and fpdn_back
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------------
//  input    | push / full          | in_weight_raw, in_activation, in_last_term,
//           |                      | in_bias_raw
//  result   | empty / pop          | out_neuron_out
//  config   | cfg_wr_en            | cfg_index, cfg_wdata
//
// one term transfers per cycle unless the result queue is full; the back end
// 32x32 product is fully pipelined, so the accumulator loop is the only recurrence
// a result's last term passes from the front register through the term queue,
// the product, shift and round and result queue registers to the result ports
// synchronous rst_n clears the queues, valids, accumulator and config registers
// a full result queue stalls the back end; the term queue then absorbs the front
module fixed_point_dense_neuron #(
  parameter int WEIGHT_BITS = 16,
  parameter int TERM_DEPTH  = 4,
  parameter int OUT_DEPTH   = 2
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [WEIGHT_BITS-1:0]        in_weight_raw,
  input  logic signed [31:0]                   in_activation,
  input  logic                                 in_last_term,
  input  logic signed [WEIGHT_BITS-1:0]        in_bias_raw,
  // result channel
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [31:0]                   out_neuron_out,
  // configuration write port
  input  logic                                 cfg_wr_en,
  input  logic [fpdn_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [fpdn_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  // configuration registers
  fpdn_pkg::cfg_t  cfg_r, cfg_nxt;

  // front to term queue
  logic            tq_wr, tq_full;
  fpdn_pkg::term_t tq_wr_data;

  // term queue to back
  logic            tq_rd, tq_empty;
  fpdn_pkg::term_t tq_rd_data;

  // back to result queue
  logic            rq_wr, rq_full;
  logic [31:0]     rq_wr_data, rq_rd_data;

  // user must make register writes only while idle; not enforced here
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        fpdn_pkg::REG_FRAC_BITS:     cfg_nxt.frac_bits     = cfg_wdata[5:0];
        fpdn_pkg::REG_BIAS_ENABLE:   cfg_nxt.bias_enable   = cfg_wdata[0];
        fpdn_pkg::REG_RELU_ENABLE:   cfg_nxt.relu_enable   = cfg_wdata[0];
        fpdn_pkg::REG_WEIGHT_SCALE:  cfg_nxt.weight_scale  = cfg_wdata;
        fpdn_pkg::REG_WEIGHT_OFFSET: cfg_nxt.weight_offset = cfg_wdata;
        fpdn_pkg::REG_BIAS_SCALE:    cfg_nxt.bias_scale    = cfg_wdata;
        fpdn_pkg::REG_BIAS_OFFSET:   cfg_nxt.bias_offset   = cfg_wdata;
        default: ; // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frac_bits     <= '0;
      cfg_r.bias_enable   <= 1'b0;
      cfg_r.relu_enable   <= 1'b0;
      cfg_r.weight_scale  <= 32'sd1;
      cfg_r.weight_offset <= '0;
      cfg_r.bias_scale    <= 32'sd1;
      cfg_r.bias_offset   <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: input register plus weight and bias dequantization
  fpdn_front #(
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .push       (push),
    .full       (full),
    .weight_raw (in_weight_raw),
    .activation (in_activation),
    .last_term  (in_last_term),
    .bias_raw   (in_bias_raw),
    .q_wr       (tq_wr),
    .q_data     (tq_wr_data),
    .q_full     (tq_full)
  );

  // decouples the front from back end stalls
  fpdn_fifo #(
    .WIDTH ($bits(fpdn_pkg::term_t)),
    .DEPTH (TERM_DEPTH)
  ) u_term_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (tq_wr),
    .wr_data (tq_wr_data),
    .full    (tq_full),
    .rd_en   (tq_rd),
    .rd_data (tq_rd_data),
    .empty   (tq_empty)
  );

  // back: multiply, shift and round, accumulate, finish on last term
  fpdn_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_empty  (tq_empty),
    .q_data   (tq_rd_data),
    .q_rd     (tq_rd),
    .out_full (rq_full),
    .out_wr   (rq_wr),
    .out_data (rq_wr_data)
  );

  // finished results wait here until popped
  fpdn_fifo #(
    .WIDTH (32),
    .DEPTH (OUT_DEPTH)
  ) u_result_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (rq_wr),
    .wr_data (rq_wr_data),
    .full    (rq_full),
    .rd_en   (pop),
    .rd_data (rq_rd_data),
    .empty   (empty)
  );

  assign out_neuron_out = rq_rd_data;

endmodule

>>> design/fpdn_fifo.sv
// small first-in first-out queue of flop storage
// no package dependency
module fpdn_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> design/fpdn_front.sv
// front end: accepts input items and dequantizes weight and bias
// depends on fpdn_pkg
module fpdn_front #(
  parameter int WEIGHT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fpdn_pkg::cfg_t                cfg,
  input  logic                          push,
  output logic                          full,
  input  logic signed [WEIGHT_BITS-1:0] weight_raw,
  input  logic signed [31:0]            activation,
  input  logic                          last_term,
  input  logic signed [WEIGHT_BITS-1:0] bias_raw,
  output logic                          q_wr,
  output fpdn_pkg::term_t               q_data,
  input  logic                          q_full
);

  logic                 valid_r, valid_nxt;
  fpdn_pkg::term_t      item_r, item_nxt;
  logic                 load;
  logic signed [31:0]   weight_ext, bias_ext;

  assign weight_ext = 32'(weight_raw);
  assign bias_ext   = 32'(bias_raw);

  assign full   = valid_r && q_full;
  assign load   = push && !full;
  assign q_wr   = valid_r && !q_full;
  assign q_data = item_r;

  always_comb begin
    valid_nxt           = load || (valid_r && q_full);
    item_nxt.weight     = cfg.weight_scale * weight_ext + cfg.weight_offset;
    item_nxt.activation = activation;
    item_nxt.last_term  = last_term;
    item_nxt.bias       = cfg.bias_scale * bias_ext + cfg.bias_offset;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_nxt;
    end
  end

endmodule

>>> design/fpdn_back.sv
// back end: product, shift and round, accumulate, bias and relu
// depends on fpdn_pkg and fixed_point_dense_neuron_macros.svh
`include "fixed_point_dense_neuron_macros.svh"

module fpdn_back (
  input  logic            clk,
  input  logic            rst_n,
  input  fpdn_pkg::cfg_t  cfg,
  input  logic            q_empty,
  input  fpdn_pkg::term_t q_data,
  output logic            q_rd,
  input  logic            out_full,
  output logic            out_wr,
  output logic [31:0]     out_data
);

  logic               adv;

  logic               s1_valid_r, s1_valid_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic               s1_last_r;
  logic [31:0]        s1_bias_r;

  logic               s2_valid_r, s2_valid_nxt;
  logic [31:0]        term_r, term_nxt;
  logic               s2_last_r;
  logic [31:0]        s2_bias_r;

  logic [31:0]        acc_r, acc_nxt;
  logic signed [63:0] shifted;
  logic [31:0]        sum, total;

  assign adv          = !out_full;
  assign q_rd         = adv && !q_empty;
  assign s1_valid_nxt = !q_empty;
  assign s2_valid_nxt = s1_valid_r;

  assign prod_nxt = 64'(q_data.weight) * 64'(q_data.activation);

  always_comb begin
    shifted  = prod_r >>> cfg.frac_bits;
    term_nxt = shifted[31:0] - {31'd0, prod_r[63]};
  end

  always_comb begin
    sum   = acc_r + term_r;
    total = cfg.bias_enable ? (sum + s2_bias_r) : sum;
    if (cfg.relu_enable && total[31]) begin
      total = '0;
    end
    out_wr   = adv && s2_valid_r && s2_last_r;
    out_data = total;
    acc_nxt  = acc_r;
    if (adv && s2_valid_r) begin
      acc_nxt = s2_last_r ? '0 : sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      acc_r      <= '0;
    end else begin
      if (adv) begin
        s1_valid_r <= s1_valid_nxt;
        s2_valid_r <= s2_valid_nxt;
      end
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r    <= prod_nxt;
      s1_last_r <= q_data.last_term;
      s1_bias_r <= q_data.bias;
      term_r    <= term_nxt;
      s2_last_r <= s1_last_r;
      s2_bias_r <= s1_bias_r;
    end
  end

  `FPDN_ASSERT(a_rd_not_empty, q_rd |-> !q_empty, "term queue read while empty")
  `FPDN_ASSERT(a_wr_not_full, out_wr |-> !out_full, "result written into full queue")
  `FPDN_ASSERT(a_relu_nonneg, (out_wr && cfg.relu_enable) |-> !out_data[31], "relu let a negative through")
  `FPDN_ASSERT_NEXT(a_acc_clear, out_wr, acc_r == '0, "accumulator not cleared after last term")

endmodule
